>>> rtl/tacf_pkg.sv
// ----------------------------------------------------------------------------
// tacf_pkg: shared types, constants and microcode for the tilt filter
// Holds the control word layout, the FIR tap table, the saturation helper and
// the read-only program that the sequencer steps through.
// ----------------------------------------------------------------------------
`default_nettype none

package tacf_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int TAPS            = 5;
  localparam int TAP_IDX_W       = 3;
  localparam int STEP_W          = 4;
  localparam int ANGLE_W         = 32;
  localparam int GAIN_W          = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // shared multiplier: a operand covers the widest difference or sum, b a
  // 16-bit unsigned gain or its negation
  localparam int OP_A_W = 35;
  localparam int OP_B_W = 17;
  localparam int PROD_W = OP_A_W + OP_B_W;
  localparam int ACC_W  = OP_A_W;

  // -1.0 in Q.16, used to fold the accelerometer offset into the fir sum
  localparam logic signed [OP_B_W-1:0] NEG_UNIT = 17'sh10000;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_ACCEL_BIAS   = 16'd512;
  localparam logic [CFG_DATA_W-1:0] RST_GYRO_BIAS    = 16'd512;
  localparam logic [CFG_DATA_W-1:0] RST_STEER_OFFSET = 16'd512;
  localparam logic [GAIN_W-1:0]     RST_ACCEL_GAIN   = 16'd256;
  localparam logic [GAIN_W-1:0]     RST_GYRO_GAIN    = 16'd83;
  localparam logic [GAIN_W-1:0]     RST_TICK_PERIOD  = 16'd328;
  localparam logic [GAIN_W-1:0]     RST_CORR_RATE    = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_BIAS,
    CFG_GYRO_BIAS,
    CFG_STEER_OFFSET,
    CFG_ACCEL_GAIN,
    CFG_GYRO_GAIN,
    CFG_TICK_PERIOD,
    CFG_CORR_RATE
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] accel_bias;
    logic [CFG_DATA_W-1:0] gyro_bias;
    logic [CFG_DATA_W-1:0] steer_offset;
    logic [GAIN_W-1:0]     accel_gain;
    logic [GAIN_W-1:0]     gyro_gain;
    logic [GAIN_W-1:0]     tick_period;
    logic [GAIN_W-1:0]     corr_rate;
  } cfg_t;

  typedef enum logic [3:0] {
    A_ZERO,
    A_SAMPLE,
    A_ACC_OFFSET,
    A_GYRO_DIFF,
    A_STEER_DIFF,
    A_ACC,
    A_TILT_ERR,
    A_SRATE,
    A_ACC_RATE,
    A_RATE
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ZERO,
    B_TAP,
    B_NEG_UNIT,
    B_NEG_GGAIN,
    B_NEG_AGAIN,
    B_CRATE,
    B_TICK
  } b_sel_t;

  // what happens to the product of the previous step
  typedef enum logic [3:0] {
    WB_NONE,
    WB_ACC_LOAD,
    WB_ACC_ADD,
    WB_TILT,
    WB_RATE,
    WB_SRATE,
    WB_ACC_CORR,
    WB_STEER,
    WB_GYRO,
    WB_FUSED
  } wb_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_IN_WAIT,
    JMP_OUT_WAIT
  } jmp_t;

  typedef struct packed {
    a_sel_t               a_sel;
    b_sel_t               b_sel;
    logic [TAP_IDX_W-1:0] tap;
    wb_t                  wb;
    logic                 adv_ring;
    jmp_t                 jmp;
    logic [STEP_W-1:0]    target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } seq_status_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic out_load;
  } seq_hs_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] tilt;
    logic signed [ANGLE_W-1:0] prev;
    logic signed [ANGLE_W-1:0] rate;
    logic signed [ANGLE_W-1:0] gyro;
    logic signed [ANGLE_W-1:0] steer;
  } results_t;

  // fir taps, coefficient times gain in Q0.16, newest sample first
  function automatic logic [GAIN_W-1:0] fir_tap(input logic [TAP_IDX_W-1:0] idx);
    logic [GAIN_W-1:0] t;
    case (idx)
      3'd0:    t = 16'd1043;
      3'd1:    t = 16'd9372;
      3'd2:    t = 16'd22874;
      3'd3:    t = 16'd22874;
      3'd4:    t = 16'd9372;
      default: t = 16'd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [ANGLE_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[ANGLE_W-1:0];
    end
    return r;
  endfunction

  function automatic ctrl_t uword(input a_sel_t a, input b_sel_t b,
                                 input logic [TAP_IDX_W-1:0] tap, input wb_t wb,
                                 input logic adv, input jmp_t jmp,
                                 input logic [STEP_W-1:0] target);
    ctrl_t c;
    c.a_sel    = a;
    c.b_sel    = b;
    c.tap      = tap;
    c.wb       = wb;
    c.adv_ring = adv;
    c.jmp      = jmp;
    c.target   = target;
    return c;
  endfunction

  // the program: one multiply issued per step, its product written back
  // by the following step
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    unique case (step)
      4'd0:  c = uword(A_ZERO,       B_ZERO,      3'd0, WB_NONE,     1'b0, JMP_IN_WAIT,  4'd0);
      4'd1:  c = uword(A_SAMPLE,     B_TAP,       3'd0, WB_NONE,     1'b0, JMP_NONE,     4'd0);
      4'd2:  c = uword(A_SAMPLE,     B_TAP,       3'd1, WB_ACC_LOAD, 1'b0, JMP_NONE,     4'd0);
      4'd3:  c = uword(A_SAMPLE,     B_TAP,       3'd2, WB_ACC_ADD,  1'b0, JMP_NONE,     4'd0);
      4'd4:  c = uword(A_SAMPLE,     B_TAP,       3'd3, WB_ACC_ADD,  1'b0, JMP_NONE,     4'd0);
      4'd5:  c = uword(A_SAMPLE,     B_TAP,       3'd4, WB_ACC_ADD,  1'b0, JMP_NONE,     4'd0);
      4'd6:  c = uword(A_ACC_OFFSET, B_NEG_UNIT,  3'd0, WB_ACC_ADD,  1'b0, JMP_NONE,     4'd0);
      4'd7:  c = uword(A_GYRO_DIFF,  B_NEG_GGAIN, 3'd0, WB_ACC_ADD,  1'b0, JMP_NONE,     4'd0);
      4'd8:  c = uword(A_ACC,        B_NEG_AGAIN, 3'd0, WB_RATE,     1'b0, JMP_NONE,     4'd0);
      4'd9:  c = uword(A_STEER_DIFF, B_NEG_AGAIN, 3'd0, WB_TILT,     1'b0, JMP_NONE,     4'd0);
      4'd10: c = uword(A_TILT_ERR,   B_CRATE,     3'd0, WB_SRATE,    1'b0, JMP_NONE,     4'd0);
      4'd11: c = uword(A_SRATE,      B_TICK,      3'd0, WB_ACC_CORR, 1'b0, JMP_NONE,     4'd0);
      4'd12: c = uword(A_ACC_RATE,   B_TICK,      3'd0, WB_STEER,    1'b0, JMP_NONE,     4'd0);
      4'd13: c = uword(A_RATE,       B_TICK,      3'd0, WB_FUSED,    1'b0, JMP_NONE,     4'd0);
      4'd14: c = uword(A_ZERO,       B_ZERO,      3'd0, WB_GYRO,     1'b1, JMP_NONE,     4'd0);
      4'd15: c = uword(A_ZERO,       B_ZERO,      3'd0, WB_NONE,     1'b0, JMP_OUT_WAIT, 4'd15);
      default: c = uword(A_ZERO,     B_ZERO,      3'd0, WB_NONE,     1'b0, JMP_NONE,     4'd0);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tilt_angle_complementary_filter_core.sv
// ----------------------------------------------------------------------------
// tilt_angle_complementary_filter_core: tilt estimator top level
// Usage:
//   input beat: one accelerometer, tilt gyro and steering gyro sample per
//     control tick, taken on in_valid && in_ready
//   output beat: accel_tilt, fused_angle (value before this tick's update),
//     tilt_rate, gyro_only_angle and steer_angle, all signed Q16.16,
//     presented on out_valid until out_ready
//   config: cfg_index selects the register, cfg_data the value; writes are
//     taken every cycle and belong in idle periods only
// Timing: a beat accepted at step 0 runs through a 16-word program on one
//   shared 35x17 multiplier, used once per step; the result is loaded into
//   the output register at the last step, and no new input beat is taken
//   until the program has returned to step 0.
// Reset clears the sample ring, ring position and the three integrals and
//   loads the register defaults; out_valid drops.
// A stalled receiver holds the output register; the next beat may be taken
//   and computed meanwhile, then the sequencer waits on its last step until
//   the output register frees up, and in_ready stays low until then.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_angle_complementary_filter_core
  import tacf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input samples
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    accel_sample,
  input  logic [SAMPLE_BITS-1:0]    tilt_gyro_sample,
  input  logic [SAMPLE_BITS-1:0]    steer_gyro_sample,
  // results
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ANGLE_W-1:0] accel_tilt,
  output logic signed [ANGLE_W-1:0] fused_angle,
  output logic signed [ANGLE_W-1:0] tilt_rate,
  output logic signed [ANGLE_W-1:0] gyro_only_angle,
  output logic signed [ANGLE_W-1:0] steer_angle,
  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t        cfg;
  ctrl_t       ctrl;
  seq_hs_t     hs;
  seq_status_t status;
  results_t    res;

  // register file is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_bias   <= RST_ACCEL_BIAS;
      cfg.gyro_bias    <= RST_GYRO_BIAS;
      cfg.steer_offset <= RST_STEER_OFFSET;
      cfg.accel_gain   <= RST_ACCEL_GAIN;
      cfg.gyro_gain    <= RST_GYRO_GAIN;
      cfg.tick_period  <= RST_TICK_PERIOD;
      cfg.corr_rate    <= RST_CORR_RATE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        // offsets keep only the sample width
        CFG_ACCEL_BIAS:   cfg.accel_bias   <= CFG_DATA_W'(cfg_data[SAMPLE_BITS-1:0]);
        CFG_GYRO_BIAS:    cfg.gyro_bias    <= CFG_DATA_W'(cfg_data[SAMPLE_BITS-1:0]);
        CFG_STEER_OFFSET: cfg.steer_offset <= CFG_DATA_W'(cfg_data[SAMPLE_BITS-1:0]);
        CFG_ACCEL_GAIN:   cfg.accel_gain   <= cfg_data;
        CFG_GYRO_GAIN:    cfg.gyro_gain    <= cfg_data;
        CFG_TICK_PERIOD:  cfg.tick_period  <= cfg_data;
        CFG_CORR_RATE:    cfg.corr_rate    <= cfg_data;
        default:          ;  // unused index, write dropped
      endcase
    end
  end

  // sequencer sees the input beat and whether the output slot is held
  assign status.in_valid = in_valid;
  assign status.out_busy = out_valid && !out_ready;

  tacf_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .hs     (hs)
  );

  tacf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .hs                (hs),
    .cfg               (cfg),
    .accel_sample      (accel_sample),
    .tilt_gyro_sample  (tilt_gyro_sample),
    .steer_gyro_sample (steer_gyro_sample),
    .res               (res)
  );

  assign in_ready = hs.in_ready;

  // output register, decouples the receiver from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hs.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hs.out_load) begin
      accel_tilt      <= res.tilt;
      fused_angle     <= res.prev;
      tilt_rate       <= res.rate;
      gyro_only_angle <= res.gyro;
      steer_angle     <= res.steer;
    end
  end

`ifndef SYNTHESIS
  // once a beat is taken the program runs, so no second beat right behind it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while program still running");

  // a finished result always lands in the output register
  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    hs.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

  // the sequencer never overwrites a result the receiver still holds
  a_no_load_over_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !hs.out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> rtl/tacf_useq.sv
// ----------------------------------------------------------------------------
// tacf_useq: microcode sequencer
// Step counter over the program table with conditional self-jumps that wait
// for an input beat and for a free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module tacf_useq
  import tacf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ctrl_t       ctrl,
  output seq_hs_t     hs
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              stay;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = ucode(step);
    unique case (ctrl.jmp)
      JMP_NONE:     stay = 1'b0;
      JMP_IN_WAIT:  stay = !status.in_valid;
      JMP_OUT_WAIT: stay = status.out_busy;
      default:      stay = 1'b0;
    endcase
    step_next   = stay ? ctrl.target : step + 1'b1;
    hs.in_ready = (ctrl.jmp == JMP_IN_WAIT);
    hs.accept   = hs.in_ready && status.in_valid;
    hs.out_load = (ctrl.jmp == JMP_OUT_WAIT) && !status.out_busy;
  end

endmodule

`default_nettype wire

>>> rtl/tacf_datapath.sv
// ----------------------------------------------------------------------------
// tacf_datapath: shared multiply datapath
// Sample ring, operand selects, one registered signed multiplier, an
// accumulator and the angle and rate registers written back under microcode.
// ----------------------------------------------------------------------------
`default_nettype none

module tacf_datapath
  import tacf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_t                  ctrl,
  input  seq_hs_t                hs,
  input  cfg_t                   cfg,
  input  logic [SAMPLE_BITS-1:0] accel_sample,
  input  logic [SAMPLE_BITS-1:0] tilt_gyro_sample,
  input  logic [SAMPLE_BITS-1:0] steer_gyro_sample,
  output results_t               res
);

  localparam int DIFF_W = CFG_DATA_W + 1;

  logic [SAMPLE_BITS-1:0]     ring [TAPS];
  logic [TAP_IDX_W-1:0]       pos;
  logic [SAMPLE_BITS-1:0]     gyro_s;
  logic [SAMPLE_BITS-1:0]     steer_s;

  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ANGLE_W-1:0]  tilt;
  logic signed [ANGLE_W-1:0]  rate;
  logic signed [ANGLE_W-1:0]  srate;
  logic signed [ANGLE_W-1:0]  prev;
  logic signed [ANGLE_W-1:0]  fused;
  logic signed [ANGLE_W-1:0]  gyro_int;
  logic signed [ANGLE_W-1:0]  steer_int;

  logic [TAP_IDX_W:0]         idx_sum;
  logic [TAP_IDX_W-1:0]       idx;
  logic signed [DIFF_W-1:0]   gdiff;
  logic signed [DIFF_W-1:0]   sdiff;
  logic signed [OP_A_W-1:0]   op_a;
  logic signed [OP_B_W-1:0]   op_b;
  logic signed [63:0]         p64;
  logic signed [63:0]         p_shr8;
  logic signed [63:0]         p_shl8;
  logic signed [63:0]         p_shr16;

  // ring read address, wraps modulo the tap count
  assign idx_sum = {1'b0, pos} + {1'b0, ctrl.tap};
  assign idx     = (idx_sum >= (TAP_IDX_W+1)'(TAPS)) ?
                   TAP_IDX_W'(idx_sum - (TAP_IDX_W+1)'(TAPS)) : TAP_IDX_W'(idx_sum);

  assign gdiff = $signed(DIFF_W'(gyro_s)) - $signed(DIFF_W'(cfg.gyro_bias));
  assign sdiff = $signed(DIFF_W'(steer_s)) - $signed(DIFF_W'(cfg.steer_offset));

  always_comb begin
    case (ctrl.a_sel)
      A_SAMPLE:     op_a = $signed(OP_A_W'(ring[idx]));
      A_ACC_OFFSET: op_a = $signed(OP_A_W'(cfg.accel_bias));
      A_GYRO_DIFF:  op_a = OP_A_W'(gdiff);
      A_STEER_DIFF: op_a = OP_A_W'(sdiff);
      A_ACC:        op_a = acc;
      A_TILT_ERR:   op_a = OP_A_W'(OP_A_W'(tilt) - OP_A_W'(prev));
      A_SRATE:      op_a = OP_A_W'(srate);
      A_ACC_RATE:   op_a = acc + OP_A_W'(rate);
      A_RATE:       op_a = OP_A_W'(rate);
      default:      op_a = '0;
    endcase
    case (ctrl.b_sel)
      B_TAP:        op_b = $signed({1'b0, fir_tap(ctrl.tap)});
      B_NEG_UNIT:   op_b = NEG_UNIT;
      B_NEG_GGAIN:  op_b = -$signed({1'b0, cfg.gyro_gain});
      B_NEG_AGAIN:  op_b = -$signed({1'b0, cfg.accel_gain});
      B_CRATE:      op_b = $signed({1'b0, cfg.corr_rate});
      B_TICK:       op_b = $signed({1'b0, cfg.tick_period});
      default:      op_b = '0;
    endcase
  end

  // shifted views of the previous product
  assign p64     = 64'(prod);
  assign p_shr8  = p64 >>> 8;
  assign p_shl8  = p64 <<< 8;
  assign p_shr16 = p64 >>> 16;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
    case (ctrl.wb)
      WB_ACC_LOAD: acc   <= ACC_W'(prod);
      WB_ACC_ADD:  acc   <= acc + ACC_W'(prod);
      WB_TILT:     tilt  <= sat32(p_shr8);
      WB_RATE:     rate  <= sat32(p_shl8);
      WB_SRATE:    srate <= sat32(p_shl8);
      WB_ACC_CORR: acc   <= ACC_W'(p_shr16);
      default:     ;
    endcase
    if (hs.accept) begin
      gyro_s  <= tilt_gyro_sample;
      steer_s <= steer_gyro_sample;
      prev    <= fused;
    end
  end

  // filter state and integrals
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        ring[i] <= '0;
      end
      pos       <= '0;
      fused     <= '0;
      gyro_int  <= '0;
      steer_int <= '0;
    end else begin
      if (hs.accept) begin
        ring[pos] <= accel_sample;
      end
      if (ctrl.adv_ring) begin
        pos <= (pos == TAP_IDX_W'(TAPS - 1)) ? '0 : pos + 1'b1;
      end
      case (ctrl.wb)
        WB_STEER: steer_int <= sat32(64'(steer_int) + p_shr16);
        WB_GYRO:  gyro_int  <= sat32(64'(gyro_int) + p_shr16);
        WB_FUSED: fused     <= sat32(64'(fused) + p_shr16);
        default:  ;
      endcase
    end
  end

  assign res.tilt  = tilt;
  assign res.prev  = prev;
  assign res.rate  = rate;
  assign res.gyro  = gyro_int;
  assign res.steer = steer_int;

endmodule

`default_nettype wire
